@@ rtl/tfhs_pkg.sv @@
`default_nettype none
package tfhs_pkg;

  localparam int TEMP_W     = 16;
  localparam int POS_W      = 28;
  localparam int COEF_W     = 16;
  localparam int AZ_W       = 15;
  localparam int WLEN_W     = 11;
  localparam int THR_W      = 15;
  localparam int HEAD_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;
  localparam int FRAC_SHIFT = 15;

  localparam int MAX_WINDOW_DEF = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_AZIMUTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_SINE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_COSINE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_BOUND     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_BOUND      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_THRESHOLD = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_START_AZIMUTH  = 3'd7;

  localparam logic signed [TEMP_W-1:0] REF_UNSET   = -16'sd256;
  localparam logic [HEAD_W-1:0]        HEADING_OFS = 17'd11520;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ACC,
    ST_CHECK,
    ST_DIV,
    ST_DECIDE,
    ST_BOUND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic mul_sel_y;
    logic div_start;
  } ctl_t;

endpackage
`default_nettype wire

@@ rtl/tfhs_if.sv @@
`default_nettype none
interface tfhs_in_if;
  import tfhs_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [TEMP_W-1:0]  temperature;
  logic signed [POS_W-1:0]   pos_x;
  logic signed [POS_W-1:0]   pos_y;
  modport source (output valid, output temperature, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input temperature, input pos_x, input pos_y, output ready);
endinterface

interface tfhs_out_if;
  import tfhs_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [HEAD_W-1:0]  heading;
  logic                      far_side;
  modport source (output valid, output heading, output far_side, input ready);
  modport sink   (input valid, input heading, input far_side, output ready);
endinterface
`default_nettype wire

@@ rtl/tfhs_div.sv @@
`default_nettype none
module tfhs_div
  import tfhs_pkg::*;
#(
  parameter int SUM_W = 27,
  parameter int CNT_W = 11
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [SUM_W-1:0]  dividend,
  input  wire logic        [CNT_W-1:0]  divisor,
  output      logic                     done,
  output      logic signed [TEMP_W-1:0] quotient
);

  localparam int IT_W = $clog2(SUM_W + 1);

  logic             busy_r, done_r, neg_r;
  logic [IT_W-1:0]  iter_r;
  logic [CNT_W-1:0] rem_r;
  logic [SUM_W-1:0] quo_r;
  logic [CNT_W-1:0] dvs_r;

  logic [CNT_W:0]    shifted;
  logic              ge;
  logic [TEMP_W-1:0] mag;
  logic [TEMP_W-1:0] q_signed;

  assign shifted  = {rem_r, quo_r[SUM_W-1]};
  assign ge       = shifted >= {1'b0, dvs_r};
  assign mag      = quo_r[TEMP_W-1:0];
  assign q_signed = neg_r ? (~mag + 1'b1) : mag;
  assign quotient = $signed(q_signed);
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        iter_r <= IT_W'(SUM_W);
      end else if (busy_r) begin
        iter_r <= iter_r - 1'b1;
        if (iter_r == IT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      neg_r <= dividend[SUM_W-1];
      quo_r <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? CNT_W'(shifted - {1'b0, dvs_r}) : shifted[CNT_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

@@ rtl/thermal_front_heading_selector.sv @@
`default_nettype none
// Thermal front heading selector. Each item (temperature, pos_x, pos_y) is
// projected onto the survey axis through one shared 28x16 multiplier (two
// passes), added into the window sum, and answered with one result item
// (heading, far_side). An item is taken only in the idle state, so a new item
// waits until the last one's result has been handed to the output register; an
// item that closes a window also waits on the bit-serial divider that forms
// the window mean. A finished result waits in the output register while the
// next item is taken; a result still held there when the next one is
// finished stalls the block until it is taken.
module thermal_front_heading_selector
  import tfhs_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tfhs_in_if.sink                    in_chan,
  tfhs_out_if.source                 out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = TEMP_W + 1 + $clog2(MAX_WINDOW);
  localparam int WC_W   = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
  localparam int PROD_W = POS_W + COEF_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int PROJ_W = ACC_W - FRAC_SHIFT;

  // configuration
  logic        [AZ_W-1:0]   axis_az_r, start_az_r;
  logic signed [COEF_W-1:0] sine_r, cosine_r;
  logic signed [POS_W-1:0]  near_r, far_r;
  logic        [WLEN_W-1:0] wlen_r;
  logic        [THR_W-1:0]  thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_az_r  <= '0;
      sine_r     <= '0;
      cosine_r   <= 16'sd32767;
      near_r     <= '0;
      far_r      <= 28'sd16000;
      wlen_r     <= 11'd10;
      thr_r      <= 15'd128;
      start_az_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AXIS_AZIMUTH:   axis_az_r  <= cfg_data[AZ_W-1:0];
        REG_AXIS_SINE:      sine_r     <= $signed(cfg_data[COEF_W-1:0]);
        REG_AXIS_COSINE:    cosine_r   <= $signed(cfg_data[COEF_W-1:0]);
        REG_NEAR_BOUND:     near_r     <= $signed(cfg_data[POS_W-1:0]);
        REG_FAR_BOUND:      far_r      <= $signed(cfg_data[POS_W-1:0]);
        REG_WINDOW_LENGTH:  wlen_r     <= cfg_data[WLEN_W-1:0];
        REG_TEMP_THRESHOLD: thr_r      <= cfg_data[THR_W-1:0];
        REG_START_AZIMUTH:  start_az_r <= cfg_data[AZ_W-1:0];
        default: ;
      endcase
    end
  end

  // state
  state_t state_r, state_nxt;
  ctl_t   ctl;

  logic        [CNT_W-1:0]  count_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [TEMP_W-1:0] ref_r;
  logic                     side_r;

  logic signed [POS_W-1:0]  px_r, py_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic                     out_valid_r;
  logic signed [HEAD_W-1:0] heading_r;
  logic                     far_side_r;

  logic                     div_done;
  logic signed [TEMP_W-1:0] div_q;

  logic                     in_accept, out_free;
  logic        [WC_W-1:0]   win_eff;
  logic                     win_close;
  logic signed [POS_W-1:0]  mul_a;
  logic signed [COEF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROJ_W-1:0] proj;
  logic signed [PROJ_W-1:0] far_ext, near_ext;
  logic signed [TEMP_W:0]   diff;
  logic        [TEMP_W:0]   diff_abs;
  logic        [HEAD_W-1:0] heading_far;

  assign in_accept = in_chan.valid && ctl.in_ready;
  assign out_free  = !out_valid_r || out_chan.ready;

  always_comb begin
    if (wlen_r == '0) begin
      win_eff = WC_W'(1);
    end else if (WC_W'(wlen_r) > WC_W'(MAX_WINDOW)) begin
      win_eff = WC_W'(MAX_WINDOW);
    end else begin
      win_eff = WC_W'(wlen_r);
    end
  end
  assign win_close = WC_W'(count_r) >= win_eff;

  assign mul_a = ctl.mul_sel_y ? py_r : px_r;
  assign mul_b = ctl.mul_sel_y ? cosine_r : sine_r;
  assign mul_p = mul_a * mul_b;

  assign proj     = acc_r[ACC_W-1:FRAC_SHIFT];
  assign far_ext  = PROJ_W'(far_r);
  assign near_ext = PROJ_W'(near_r);

  assign diff     = (TEMP_W+1)'(div_q) - (TEMP_W+1)'(ref_r);
  assign diff_abs = diff[TEMP_W] ? (~diff + 1'b1) : diff;

  assign heading_far = HEADING_OFS + HEAD_W'(start_az_r)
                     + ((HEAD_W'(axis_az_r) - HEAD_W'(start_az_r)) << 1);

  tfhs_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_chan.valid) state_nxt = ST_MUL_X;
      ST_MUL_X:  state_nxt = ST_MUL_Y;
      ST_MUL_Y:  state_nxt = ST_ACC;
      ST_ACC:    state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = win_close ? ST_DIV : ST_BOUND;
      ST_DIV:    if (div_done) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_BOUND;
      ST_BOUND:  state_nxt = ST_OUT;
      ST_OUT:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_IDLE:  ctl.in_ready  = 1'b1;
      ST_MUL_Y: ctl.mul_sel_y = 1'b1;
      ST_CHECK: ctl.div_start = win_close;
      default: ;
    endcase
  end

  assign in_chan.ready = ctl.in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      sum_r   <= '0;
      ref_r   <= REF_UNSET;
      side_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        count_r <= count_r + 1'b1;
        sum_r   <= sum_r + SUM_W'(in_chan.temperature);
      end
      if (state_r == ST_DECIDE) begin
        count_r <= '0;
        sum_r   <= '0;
        if (ref_r <= 0) begin
          ref_r <= div_q;
        end else if (diff_abs >= (TEMP_W+1)'(thr_r)) begin
          side_r <= ~side_r;
          ref_r  <= div_q;
        end
      end
      if (state_r == ST_BOUND) begin
        if (proj >= far_ext) begin
          side_r <= 1'b1;
          ref_r  <= REF_UNSET;
        end else if (proj <= near_ext) begin
          side_r <= 1'b0;
          ref_r  <= REF_UNSET;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      px_r <= in_chan.pos_x;
      py_r <= in_chan.pos_y;
    end
    if (state_r == ST_MUL_X || state_r == ST_MUL_Y) begin
      prod_r <= mul_p;
    end
    if (state_r == ST_MUL_Y) begin
      acc_r <= ACC_W'(prod_r);
    end
    if (state_r == ST_ACC) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      heading_r  <= side_r ? $signed(heading_far) : $signed(HEAD_W'(start_az_r));
      far_side_r <= side_r;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.heading  = heading_r;
  assign out_chan.far_side = far_side_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> state_r == ST_IDLE)
    else $error("ready outside idle");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    WC_W'(count_r) <= WC_W'(MAX_WINDOW))
    else $error("sample count beyond window limit");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside its state");

  a_near_heading: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !far_side_r |-> heading_r == $signed(HEAD_W'(start_az_r)))
    else $error("near-side heading is not the start azimuth");
`endif

endmodule
`default_nettype wire
